### hw/rtl/mjpid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mjpid_pkg;

  // Controller sequence for one item
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_INTEG,
    ST_IPROD,
    ST_ICOMB,
    ST_DIV,
    ST_DMUL,
    ST_SUM,
    ST_DONE
  } mjpid_state_t;

  // Step strobes from the controller to every lane
  typedef struct packed {
    logic load;
    logic mul;
    logic integ;
    logic iprod;
    logic icomb;
    logic div;
    logic dmul;
    logic sum;
  } mjpid_ctl_t;

  localparam int unsigned JointsMax = 4;
  localparam int unsigned DivSteps  = 18;
  localparam int unsigned DivCntW   = 5;
  localparam int unsigned CfgIdxW   = 3;

  localparam logic [CfgIdxW-1:0] CFG_TARGET   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KP       = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KI       = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_KD       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PRESSURE = 3'd4;

  localparam logic [15:0] PressureReset = 16'd410;

endpackage

`default_nettype wire

### hw/rtl/mjpid_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mjpid_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] joint_position_0;
  logic signed [15:0] joint_position_1;
  logic signed [15:0] joint_position_2;
  logic signed [15:0] joint_position_3;
  logic        [31:0] timestamp;

  modport source (
    output valid, joint_position_0, joint_position_1, joint_position_2,
           joint_position_3, timestamp,
    input  ready
  );
  modport sink (
    input  valid, joint_position_0, joint_position_1, joint_position_2,
           joint_position_3, timestamp,
    output ready
  );
endinterface

interface mjpid_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] agonist_cmd_0;
  logic [15:0] antagonist_cmd_0;
  logic [15:0] agonist_cmd_1;
  logic [15:0] antagonist_cmd_1;
  logic [15:0] agonist_cmd_2;
  logic [15:0] antagonist_cmd_2;
  logic [15:0] agonist_cmd_3;
  logic [15:0] antagonist_cmd_3;

  modport source (
    output valid, agonist_cmd_0, antagonist_cmd_0, agonist_cmd_1, antagonist_cmd_1,
           agonist_cmd_2, antagonist_cmd_2, agonist_cmd_3, antagonist_cmd_3,
    input  ready
  );
  modport sink (
    input  valid, agonist_cmd_0, antagonist_cmd_0, agonist_cmd_1, antagonist_cmd_1,
           agonist_cmd_2, antagonist_cmd_2, agonist_cmd_3, antagonist_cmd_3,
    output ready
  );
endinterface

interface mjpid_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/mjpid_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module mjpid_lane (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire mjpid_pkg::mjpid_ctl_t  ctl,
  input  wire logic signed [15:0]     target,
  input  wire logic signed [15:0]     position,
  input  wire logic        [15:0]     kp,
  input  wire logic        [15:0]     ki,
  input  wire logic        [15:0]     kd,
  input  wire logic        [15:0]     off,
  input  wire logic        [31:0]     dt,
  output logic             [15:0]     agonist,
  output logic             [15:0]     antagonist
);
  import mjpid_pkg::*;

  localparam logic signed [49:0] IntegMax = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] IntegMin = -IntegMax - 50'sd1;
  localparam logic signed [65:0] KiClamp  = 66'sd1 <<< 40;

  logic signed [16:0] err_r;
  logic signed [16:0] last_err_r;
  logic signed [17:0] diff_r;
  logic signed [49:0] eprod_r;
  logic signed [47:0] integ_r;
  logic        [39:0] pl_r;
  logic signed [40:0] ph_r;
  logic signed [41:0] iterm_r;
  logic signed [33:0] pe_r;
  logic signed [35:0] dp_r;
  logic signed [35:0] u_r;
  logic               neg_r;
  logic        [17:0] quo_r;
  logic        [31:0] rem_r;

  logic signed [16:0] err_nxt;
  logic signed [49:0] isum;
  logic signed [47:0] integ_nxt;
  logic signed [65:0] ifull;
  logic signed [41:0] iterm_nxt;
  logic        [32:0] rem_sh;
  logic signed [18:0] deriv;
  logic signed [43:0] total;
  logic        [35:0] mag;
  logic        [36:0] active;
  logic        [15:0] active_sat;

  // Error and its change against the stored previous error
  assign err_nxt = $signed({target[15], target}) - $signed({position[15], position});

  // Accumulate error times elapsed ticks with saturation
  always_comb begin
    isum = $signed({{2{integ_r[47]}}, integ_r}) + eprod_r;
    if (isum > IntegMax) begin
      integ_nxt = IntegMax[47:0];
    end else if (isum < IntegMin) begin
      integ_nxt = IntegMin[47:0];
    end else begin
      integ_nxt = isum[47:0];
    end
  end

  // Combine integral partial products and clamp
  always_comb begin
    ifull = (66'(ph_r) <<< 24) + $signed({26'd0, pl_r});
    if (ifull > KiClamp) begin
      iterm_nxt = KiClamp[41:0];
    end else if (ifull < -KiClamp) begin
      iterm_nxt = 42'(-KiClamp);
    end else begin
      iterm_nxt = ifull[41:0];
    end
  end

  // Restoring divider step and signed quotient
  assign rem_sh = {rem_r, quo_r[17]};
  assign deriv  = (dt == 32'd0) ? 19'sd0 :
                  (neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r}));
  assign total  = 44'(iterm_r) + 44'(pe_r) + 44'(dp_r);

  // State that survives between items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r <= '0;
      integ_r    <= '0;
    end else begin
      if (ctl.load) begin
        last_err_r <= err_nxt;
      end
      if (ctl.integ) begin
        integ_r <= integ_nxt;
      end
    end
  end

  // Datapath steps
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      err_r  <= err_nxt;
      diff_r <= $signed({err_nxt[16], err_nxt}) - $signed({last_err_r[16], last_err_r});
    end
    if (ctl.mul) begin
      eprod_r <= err_r * $signed({1'b0, dt});
      neg_r   <= diff_r[17];
      quo_r   <= diff_r[17] ? 18'(-diff_r) : 18'(diff_r);
      rem_r   <= '0;
    end
    if (ctl.iprod) begin
      pl_r <= ki * integ_r[23:0];
      ph_r <= $signed({1'b0, ki}) * $signed(integ_r[47:24]);
    end
    if (ctl.icomb) begin
      iterm_r <= iterm_nxt;
      pe_r    <= $signed({1'b0, kp}) * err_r;
    end
    if (ctl.div) begin
      if (rem_sh >= {1'b0, dt}) begin
        rem_r <= 32'(rem_sh - {1'b0, dt});
        quo_r <= {quo_r[16:0], 1'b1};
      end else begin
        rem_r <= rem_sh[31:0];
        quo_r <= {quo_r[16:0], 1'b0};
      end
    end
    if (ctl.dmul) begin
      dp_r <= $signed({1'b0, kd}) * deriv;
    end
    if (ctl.sum) begin
      u_r <= 36'(total >>> 8);
    end
  end

  // Split drive into the two muscle commands
  always_comb begin
    mag        = u_r[35] ? 36'(-u_r) : 36'(u_r);
    active     = {1'b0, mag} + {21'd0, off};
    active_sat = (active > 37'd65535) ? 16'hFFFF : active[15:0];
    if (u_r[35]) begin
      agonist    = active_sat;
      antagonist = off;
    end else begin
      agonist    = off;
      antagonist = active_sat;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/multi_joint_pid_muscle_split.sv
// Items are processed one at a time: a new item is accepted only when the controller
// is idle again, after the previous result has entered the output register. Each lane
// has its own 18-step restoring divider for the derivative.
// Each joint has its own lane; all lanes run in lockstep under one controller.
// Reset (synchronous, rst_n low) clears integrators, previous errors, timestamp,
// gains and targets, and sets the pressure offset to 410.
`timescale 1ns / 1ps
`default_nettype none

module multi_joint_pid_muscle_split #(
  parameter int unsigned NUM_JOINTS = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mjpid_in_if.sink   in_ch,
  mjpid_out_if.source out_ch,
  mjpid_cfg_if.sink  cfg_ch
);
  import mjpid_pkg::*;

  logic [63:0] target_r;
  logic [63:0] kp_r;
  logic [63:0] ki_r;
  logic [63:0] kd_r;
  logic [15:0] off_r;

  logic        seen_r;
  logic [31:0] last_ts_r;
  logic [31:0] dt_r;

  mjpid_state_t       state_r;
  mjpid_state_t       state_nxt;
  logic [DivCntW-1:0] div_cnt_r;
  mjpid_ctl_t         ctl;

  logic        out_valid_r;
  logic [15:0] ago_r [JointsMax];
  logic [15:0] ant_r [JointsMax];
  logic [15:0] ago   [JointsMax];
  logic [15:0] ant   [JointsMax];
  logic signed [15:0] pos [JointsMax];

  logic in_xfer;
  logic out_free;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign pos[0] = in_ch.joint_position_0;
  assign pos[1] = in_ch.joint_position_1;
  assign pos[2] = in_ch.joint_position_2;
  assign pos[3] = in_ch.joint_position_3;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      kp_r     <= '0;
      ki_r     <= '0;
      kd_r     <= '0;
      off_r    <= PressureReset;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_TARGET:   target_r <= cfg_ch.data;
        CFG_KP:       kp_r     <= cfg_ch.data;
        CFG_KI:       ki_r     <= cfg_ch.data;
        CFG_KD:       kd_r     <= cfg_ch.data;
        CFG_PRESSURE: off_r    <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  // Elapsed time, zero on the first item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r    <= 1'b0;
      last_ts_r <= '0;
      dt_r      <= '0;
    end else if (in_xfer) begin
      seen_r    <= 1'b1;
      last_ts_r <= in_ch.timestamp;
      dt_r      <= seen_r ? (in_ch.timestamp - last_ts_r) : 32'd0;
    end
  end

  // Controller state and divider count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      div_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DIV) begin
        div_cnt_r <= div_cnt_r + DivCntW'(1);
      end else begin
        div_cnt_r <= '0;
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_xfer) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_INTEG;
      ST_INTEG: state_nxt = ST_IPROD;
      ST_IPROD: state_nxt = ST_ICOMB;
      ST_ICOMB: state_nxt = ST_DIV;
      ST_DIV:   if (div_cnt_r == DivCntW'(DivSteps - 1)) state_nxt = ST_DMUL;
      ST_DMUL:  state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Step strobes
  always_comb begin
    ctl       = '0;
    ctl.load  = in_xfer;
    ctl.mul   = (state_r == ST_MUL);
    ctl.integ = (state_r == ST_INTEG);
    ctl.iprod = (state_r == ST_IPROD);
    ctl.icomb = (state_r == ST_ICOMB);
    ctl.div   = (state_r == ST_DIV);
    ctl.dmul  = (state_r == ST_DMUL);
    ctl.sum   = (state_r == ST_SUM);
  end

  // Joint lanes; unused joints report zero
  for (genvar j = 0; j < JointsMax; j++) begin : g_lane
    if (j < NUM_JOINTS) begin : g_on
      mjpid_lane u_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .target     ($signed(target_r[16*j +: 16])),
        .position   (pos[j]),
        .kp         (kp_r[16*j +: 16]),
        .ki         (ki_r[16*j +: 16]),
        .kd         (kd_r[16*j +: 16]),
        .off        (off_r),
        .dt         (dt_r),
        .agonist    (ago[j]),
        .antagonist (ant[j])
      );
    end else begin : g_off
      assign ago[j] = '0;
      assign ant[j] = '0;
    end
  end

  // Merge lane results into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && out_free) begin
      for (int k = 0; k < JointsMax; k++) begin
        ago_r[k] <= ago[k];
        ant_r[k] <= ant[k];
      end
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.agonist_cmd_0    = ago_r[0];
  assign out_ch.antagonist_cmd_0 = ant_r[0];
  assign out_ch.agonist_cmd_1    = ago_r[1];
  assign out_ch.antagonist_cmd_1 = ant_r[1];
  assign out_ch.agonist_cmd_2    = ago_r[2];
  assign out_ch.antagonist_cmd_2 = ant_r[2];
  assign out_ch.agonist_cmd_3    = ago_r[3];
  assign out_ch.antagonist_cmd_3 = ant_r[3];

  // Checks
  a_xfer_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_MUL))
    else $error("item transfer did not start the sequence");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_cnt_r <= DivCntW'(DivSteps - 1)))
    else $error("divider count overran");

  a_seen_set: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> seen_r)
    else $error("first-sample flag not set after a transfer");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the done step");

endmodule

`default_nettype wire

### sim/mjpid_checker.sv
`timescale 1ns / 1ps

module mjpid_checker #(
  parameter int unsigned NUM_JOINTS = 4
) (
  input  logic clk,
  input  logic rst_n,
  mjpid_in_if  in_ch,
  mjpid_out_if out_ch,
  mjpid_cfg_if cfg_ch,
  output int   fail_count,
  output int   pending_count,
  output int   result_count
);
  import mjpid_pkg::*;

  typedef logic [7:0][15:0] cmd_set_t;

  localparam longint IntegMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint IntegMin = -IntegMax - 1;
  localparam longint IprodLim = 64'sd1 << 40;

  // Shadow of the block's registers and loop state
  logic [63:0] tgt_reg, kp_reg, ki_reg, kd_reg;
  logic [15:0] offset_reg;
  logic        primed;
  logic [31:0] prev_ts;
  longint      prev_err [4];
  longint      integ_acc [4];

  cmd_set_t cmd_queue [$];

  function automatic logic [15:0] clip16(longint v);
    if (v > 65535) return 16'hFFFF;
    if (v < 0) return 16'h0000;
    return v[15:0];
  endfunction

  // Advance the controller state by one sample and return its commands
  function automatic cmd_set_t advance_loop(logic [3:0][15:0] pos, logic [31:0] ts);
    cmd_set_t cmds;
    logic [31:0] dt32;
    longint dt, off, err, kp, ki, kd, integ, deriv, iterm, sum, u, mag;
    cmds = '0;
    dt32 = primed ? ts - prev_ts : 32'd0;
    dt = longint'({32'd0, dt32});
    off = longint'({48'd0, offset_reg});
    for (int j = 0; j < NUM_JOINTS && j < 4; j++) begin
      err = longint'($signed(tgt_reg[16*j +: 16])) - longint'($signed(pos[j]));
      kp = longint'({48'd0, kp_reg[16*j +: 16]});
      ki = longint'({48'd0, ki_reg[16*j +: 16]});
      kd = longint'({48'd0, kd_reg[16*j +: 16]});
      integ = integ_acc[j] + err * dt;
      if (integ > IntegMax) integ = IntegMax;
      if (integ < IntegMin) integ = IntegMin;
      integ_acc[j] = integ;
      deriv = (dt != 0) ? (err - prev_err[j]) / dt : 0;
      prev_err[j] = err;
      // Any nonzero gain on an integral beyond the clamp lands on the clamp
      if (ki == 0) iterm = 0;
      else if (integ > IprodLim) iterm = IprodLim;
      else if (integ < -IprodLim) iterm = -IprodLim;
      else begin
        iterm = ki * integ;
        if (iterm > IprodLim) iterm = IprodLim;
        if (iterm < -IprodLim) iterm = -IprodLim;
      end
      sum = kp * err + iterm + kd * deriv;
      u = sum >>> 8;
      mag = (u < 0) ? -u : u;
      if (u < 0) begin
        cmds[2*j]   = clip16(mag + off);
        cmds[2*j+1] = clip16(off);
      end else begin
        cmds[2*j]   = clip16(off);
        cmds[2*j+1] = clip16(mag + off);
      end
    end
    prev_ts = ts;
    primed = 1'b1;
    return cmds;
  endfunction

  assign pending_count = cmd_queue.size();

  // Track register writes, predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    cmd_set_t got, want;
    int errs;
    if (!rst_n) begin
      tgt_reg <= '0; kp_reg <= '0; ki_reg <= '0; kd_reg <= '0;
      offset_reg <= PressureReset;
      primed = 1'b0;
      prev_ts = '0;
      for (int j = 0; j < 4; j++) begin
        prev_err[j] = 0;
        integ_acc[j] = 0;
      end
      cmd_queue.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_TARGET:   tgt_reg <= cfg_ch.data;
          CFG_KP:       kp_reg <= cfg_ch.data;
          CFG_KI:       ki_reg <= cfg_ch.data;
          CFG_KD:       kd_reg <= cfg_ch.data;
          CFG_PRESSURE: offset_reg <= cfg_ch.data[15:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        cmd_queue.push_back(advance_loop({in_ch.joint_position_3, in_ch.joint_position_2,
                                          in_ch.joint_position_1, in_ch.joint_position_0},
                                         in_ch.timestamp));
      end
      if (out_ch.valid && out_ch.ready) begin
        result_count <= result_count + 1;
        errs = 0;
        got = {out_ch.antagonist_cmd_3, out_ch.agonist_cmd_3,
               out_ch.antagonist_cmd_2, out_ch.agonist_cmd_2,
               out_ch.antagonist_cmd_1, out_ch.agonist_cmd_1,
               out_ch.antagonist_cmd_0, out_ch.agonist_cmd_0};
        if (cmd_queue.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errs = 1;
        end else begin
          want = cmd_queue.pop_front();
          for (int k = 0; k < 8; k++) begin
            if (got[k] !== want[k]) begin
              $display("%0t: %s_cmd_%0d expected %h actual %h", $time,
                       (k % 2) ? "antagonist" : "agonist", k / 2, want[k], got[k]);
              errs++;
            end
          end
        end
        if (errs != 0) fail_count <= fail_count + errs;
      end
    end
  end
endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mjpid_pkg::*;

  localparam int IdleLimit = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending_count, result_count;
  int   idle_cycles = 0;
  int   sent = 0;
  bit   quiet_mode = 0;
  logic [31:0] ts_now = 0;

  mjpid_in_if  in_ch ();
  mjpid_out_if out_ch ();
  mjpid_cfg_if cfg_ch ();

  multi_joint_pid_muscle_split dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  mjpid_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
  );

  always #4 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.joint_position_0 = '0; in_ch.joint_position_1 = '0;
    in_ch.joint_position_2 = '0; in_ch.joint_position_3 = '0;
    in_ch.timestamp = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  function automatic int draw_gap();
    return quiet_mode ? 0 : $urandom_range(0, 18);
  endfunction

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else if (idle_cycles + 1 >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // Result side: accept with random stalls
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      stall = draw_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drop the input, then hold until every result is back and the pipeline has settled
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic send_sample(logic [63:0] pos, logic [31:0] ts);
    int gap;
    in_ch.valid <= 1'b1;
    {in_ch.joint_position_3, in_ch.joint_position_2,
     in_ch.joint_position_1, in_ch.joint_position_0} <= pos;
    in_ch.timestamp <= ts;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_gains();
    case ($urandom_range(0, 3))
      0: return rand64();
      1: return rand64() & 64'h00FF_00FF_00FF_00FF;
      2: return rand64() & 64'h000F_000F_000F_000F;
      default: return {4{16'h0100}};
    endcase
  endfunction

  function automatic logic [63:0] rand_positions();
    logic [63:0] p;
    p = rand64();
    for (int j = 0; j < 4; j++) begin
      case ($urandom_range(0, 7))
        0: p[16*j +: 16] = 16'h7FFF;
        1: p[16*j +: 16] = 16'h8000;
        2: p[16*j +: 16] = 16'($signed(p[16*j +: 8]));
        default: ;
      endcase
    end
    return p;
  endfunction

  function automatic logic [31:0] next_ts(logic [31:0] ts);
    case ($urandom_range(0, 19))
      0: return ts;
      1: return ts - $urandom_range(1, 1000);
      2: return $urandom();
      3: return ts + $urandom_range(1000, 100000);
      default: return ts + $urandom_range(1, 64);
    endcase
  endfunction

  // Stimulus and verdict
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Defaults: all gains zero, commands sit at the reset offset
    send_sample({16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF}, 32'd100);
    send_sample({16'h8000, 16'h7FFF, 16'h1234, 16'h0001}, 32'd100);
    drain();

    // Full-scale gains and targets; zero elapsed time, timestamp wrap
    write_reg(CFG_TARGET, {16'h7FFF, 16'h8000, 16'h0000, 16'h1000});
    write_reg(CFG_KP, {4{16'hFFFF}});
    write_reg(CFG_KI, {4{16'hFFFF}});
    write_reg(CFG_KD, {4{16'hFFFF}});
    write_reg(CFG_PRESSURE, 64'hFFFF);
    write_reg(3'd5, rand64());
    write_reg(3'd7, rand64());
    send_sample({16'h8000, 16'h7FFF, 16'h0000, 16'h1000}, 32'd200);
    send_sample({16'h8000, 16'h7FFF, 16'h0001, 16'hF000}, 32'd200);
    send_sample({16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000}, 32'hFFFF_FFFF);
    send_sample({16'h0000, 16'h0000, 16'h8000, 16'h7FFF}, 32'd3);
    send_sample({16'h8000, 16'h8000, 16'h8000, 16'h8000}, 32'd2);
    drain();
    write_reg(CFG_PRESSURE, 64'h0);
    write_reg(CFG_KP, {4{16'h0001}});
    write_reg(CFG_KI, 64'h0);
    write_reg(CFG_KD, {4{16'h0100}});
    send_sample({16'h7FFF, 16'h0001, 16'hFFFF, 16'h0000}, 32'd10);
    send_sample({16'h8000, 16'h0000, 16'h0001, 16'hFFFF}, 32'd11);
    send_sample({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 32'd14);
    drain();

    // Random phases, each with fresh settings
    for (int phase = 0; phase < 18; phase++) begin
      write_reg(CFG_TARGET, rand_positions());
      write_reg(CFG_KP, rand_gains());
      write_reg(CFG_KI, rand_gains());
      write_reg(CFG_KD, rand_gains());
      write_reg(CFG_PRESSURE, (phase % 3 == 0) ? 64'hFFFF : 64'($urandom_range(0, 4096)));
      if (phase % 5 == 4) write_reg(3'($urandom_range(5, 7)), rand64());
      for (int n = 0; n < 50; n++) begin
        if ($urandom_range(0, 15) == 0) quiet_mode = ~quiet_mode;
        ts_now = next_ts(ts_now);
        send_sample(rand_positions(), ts_now);
        if (n == 25 && phase % 4 == 1) drain();
      end
      quiet_mode = 0;
      drain();
    end

    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("%0d samples sent, %0d command sets checked across 21 register settings",
             sent, result_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
